// ===== rtl/urc_pkg.sv =====
// Shared types and constants for the ultrasonic range controller.
package urc_pkg;

    localparam int CNT_W         = 16;
    localparam int DIST_W        = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int SCALE_DIV_DEF = 10000;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd3;

    localparam logic [7:0]       TRIG_LOW_RST  = 8'd5;
    localparam logic [7:0]       TRIG_HIGH_RST = 8'd10;
    localparam logic [CNT_W-1:0] TIMEOUT_RST   = 16'd30000;
    localparam logic [7:0]       SCALE_RST     = 8'd171;

    typedef struct packed {
        logic [7:0]       trig_low_us;
        logic [7:0]       trig_high_us;
        logic [CNT_W-1:0] timeout_us;
        logic [7:0]       speed_scale;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic step;
    } t_dist_ev;

    typedef struct packed {
        logic trig_level;
        logic busy_res;
        logic done_res;
        logic timed_out;
        logic echo_hit;
    } t_status;

endpackage

// ===== rtl/urc_cfg.sv =====
// Configuration register bank for the ultrasonic range controller.
module urc_cfg
    import urc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_low_us  <= TRIG_LOW_RST;
            r_cfg.trig_high_us <= TRIG_HIGH_RST;
            r_cfg.timeout_us   <= TIMEOUT_RST;
            r_cfg.speed_scale  <= SCALE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRIG_LOW:  r_cfg.trig_low_us  <= i_cfg_data[7:0];
                CFG_TRIG_HIGH: r_cfg.trig_high_us <= i_cfg_data[7:0];
                CFG_TIMEOUT:   r_cfg.timeout_us   <= i_cfg_data[CNT_W-1:0];
                CFG_SCALE:     r_cfg.speed_scale  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/urc_ctrl.sv =====
// Trigger and echo sequencer of the ultrasonic range controller.
module urc_ctrl
    import urc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_start_req,
    input  logic     i_echo_level,
    input  t_cfg     i_cfg,
    output t_status  o_status,
    output t_dist_ev o_dist_ev
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TLOW,
        PH_THIGH,
        PH_WAIT
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_ecnt, n_ecnt;
    logic             r_seen, n_seen;
    logic             r_prev;
    logic             rising, falling;
    t_status          status;
    t_dist_ev         ev;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    assign rising  = i_echo_level & ~r_prev;
    assign falling = ~i_echo_level & r_prev;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_ecnt  = r_ecnt;
        n_seen  = r_seen;
        status  = '0;
        ev      = '0;
        if (r_phase == PH_IDLE && i_start_req) begin
            n_phase  = PH_TLOW;
            n_cnt    = '0;
            n_ecnt   = '0;
            n_seen   = 1'b0;
            ev.clear = 1'b1;
        end
        if (n_phase == PH_TLOW) begin
            if (n_cnt >= CNT_W'(i_cfg.trig_low_us)) begin
                n_phase = PH_THIGH;
                n_cnt   = '0;
            end else begin
                n_cnt = sat_inc(n_cnt);
            end
        end
        if (n_phase == PH_THIGH) begin
            if (n_cnt >= CNT_W'(i_cfg.trig_high_us)) begin
                n_phase = PH_WAIT;
                n_cnt   = '0;
            end else begin
                n_cnt             = sat_inc(n_cnt);
                status.trig_level = 1'b1;
            end
        end
        if (n_phase == PH_WAIT) begin
            n_cnt = sat_inc(n_cnt);
            if (n_seen) begin
                ev.step = (n_ecnt != {CNT_W{1'b1}});
                n_ecnt  = sat_inc(n_ecnt);
            end
            if (rising) begin
                n_seen   = 1'b1;
                n_ecnt   = '0;
                ev.clear = 1'b1;
            end else if (falling && n_seen) begin
                status.done_res = 1'b1;
                status.echo_hit = 1'b1;
            end
            if (!status.done_res && n_cnt >= i_cfg.timeout_us) begin
                status.done_res  = 1'b1;
                status.timed_out = 1'b1;
            end
            if (status.done_res) begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
                n_seen  = 1'b0;
            end
        end
        status.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_ecnt  <= '0;
            r_seen  <= 1'b0;
            r_prev  <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ecnt  <= n_ecnt;
            r_seen  <= n_seen;
            r_prev  <= i_echo_level;
        end
    end

    assign o_status  = status;
    assign o_dist_ev = ev;

endmodule

// ===== rtl/urc_dist.sv =====
// Running quotient of echo time times scale over the divisor.
module urc_dist
    import urc_pkg::*;
#(
    parameter int SCALE_DIVISOR = SCALE_DIV_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_dist_ev          i_ev,
    input  logic [7:0]        i_scale,
    output logic [DIST_W-1:0] o_dist
);

    localparam int REM_W = $clog2(SCALE_DIVISOR);
    localparam logic [REM_W:0] DIV_V = (REM_W + 1)'(SCALE_DIVISOR);

    logic [DIST_W-1:0] r_q, n_q;
    logic [REM_W-1:0]  r_r, n_r;
    logic [REM_W:0]    sum;

    // The remainder stays below the divisor and the scale is smaller than it,
    // so one compare and subtract per tick keeps the quotient exact.
    assign sum = {1'b0, r_r} + (REM_W + 1)'(i_scale);

    always_comb begin
        n_q = r_q;
        n_r = r_r;
        if (i_ev.clear) begin
            n_q = '0;
            n_r = '0;
        end else if (i_ev.step) begin
            if (sum >= DIV_V) begin
                n_r = REM_W'(sum - DIV_V);
                n_q = (r_q == {DIST_W{1'b1}}) ? r_q : r_q + 1'b1;
            end else begin
                n_r = REM_W'(sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
            r_r <= '0;
        end else if (i_en) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_dist = n_q;

endmodule

// ===== rtl/ultrasonic_range_controller_core.sv =====
// Ultrasonic range controller top level with handshakes and result register.
//
// Each input transfer is one microsecond tick carrying the start request and
// the sampled echo level; every tick yields exactly one result transfer with
// the trigger level, busy, done, timeout flag and distance in centimetres.
// The echo time is scaled by a running quotient that advances with each tick,
// so no divider or multiplier sits in the path.
// Each result is registered and presented in the cycle after its input transfer; one transfer is
// accepted in every cycle while the result side keeps up.
// The single result register decides the input stall: when it holds a result
// and the receiver stalls, o_stall rises and the input waits with it.
// Configuration writes are always ready and take effect on the next tick. The user must
// issue them only while no measurement is in progress; the block does not enforce this.
// A synchronous active-low reset returns the sequencer to idle, clears the
// counters and loads the register defaults: 5 us low, 10 us pulse,
// 30000 us timeout and a scale of 171.
module ultrasonic_range_controller_core
    import urc_pkg::*;
#(
    parameter int SCALE_DIVISOR = SCALE_DIV_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_start_req,
    input  logic                  i_echo_level,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_trig_level,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic                  o_timed_out,
    output logic [DIST_W-1:0]     o_distance_cm,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    t_status           status;
    t_dist_ev          dist_ev;
    logic [DIST_W-1:0] dist_cm;
    logic              in_acc;
    logic              r_out_valid;
    t_status           r_status;
    logic [DIST_W-1:0] r_dist;

    assign o_stall     = r_out_valid & i_stall;
    assign in_acc      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    urc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    urc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_acc),
        .i_start_req  (i_start_req),
        .i_echo_level (i_echo_level),
        .i_cfg        (cfg),
        .o_status     (status),
        .o_dist_ev    (dist_ev)
    );

    urc_dist #(
        .SCALE_DIVISOR (SCALE_DIVISOR)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_acc),
        .i_ev    (dist_ev),
        .i_scale (cfg.speed_scale),
        .o_dist  (dist_cm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= status;
            r_dist   <= status.echo_hit ? dist_cm : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_trig_level  = r_status.trig_level;
    assign o_busy_res    = r_status.busy_res;
    assign o_done_res    = r_status.done_res;
    assign o_timed_out   = r_status.timed_out;
    assign o_distance_cm = r_dist;

endmodule

// ===== bench/tb_ultrasonic_range_controller_core.sv =====
// Self-checking testbench for the ultrasonic range controller core.
module tb_ultrasonic_range_controller_core;
    import urc_pkg::*;

    typedef enum logic [1:0] {
        RANGER_IDLE,
        RANGER_TLOW,
        RANGER_THIGH,
        RANGER_WAIT
    } t_ranger_phase;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic              tmo;
        logic [DIST_W-1:0] range_cm;
    } t_range_res;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_SETTINGS,
        ROW_SETTLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic       start;
        logic       echo;
        logic       typed;
        t_range_res want;
        t_cfg       cfg;
    } t_plan_row;

    localparam t_range_res RES_IDLE    = '{1'b0, 1'b0, 1'b0, 1'b0, '0};
    localparam t_range_res RES_TLOW    = '{1'b0, 1'b1, 1'b0, 1'b0, '0};
    localparam t_range_res RES_PULSE   = '{1'b1, 1'b1, 1'b0, 1'b0, '0};
    localparam t_range_res RES_TIMEOUT = '{1'b0, 1'b0, 1'b1, 1'b1, '0};

    localparam t_cfg NO_CFG     = '0;
    localparam t_cfg ZERO_TIMES = '{8'd0, 8'd0, 16'd0, 8'd255};
    localparam t_cfg SHORT_RUN  = '{8'd0, 8'd1, 16'd3, 8'd255};
    localparam t_cfg WIDEST     = '{8'd255, 8'd255, 16'hFFFF, 8'd255};
    localparam t_cfg LONG_WAIT  = '{8'd0, 8'd1, 16'hFFFF, 8'd255};
    localparam t_cfg NARROWEST  = '{8'd0, 8'd1, 16'd1, 8'd1};

    localparam int NUM_ROWS      = 26;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_TICKS   = 80;
    localparam int QUIET_PHASE   = 2;
    localparam int LONG_PHASE    = 3;
    localparam int NARROW_PHASE  = 5;

    localparam t_plan_row DIRECTED_PLAN [NUM_ROWS] = '{
        '{ROW_TICK,     1'b0, 1'b0, 1'b1, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b1, 1'b1, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b0, 1'b1, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b1, 1'b0, 1'b1, RES_TLOW,    NO_CFG},
        '{ROW_TICK,     1'b1, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_SETTLE,   1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_SETTINGS, 1'b0, 1'b0, 1'b0, RES_IDLE,    ZERO_TIMES},
        '{ROW_TICK,     1'b1, 1'b0, 1'b1, RES_TIMEOUT, NO_CFG},
        '{ROW_TICK,     1'b1, 1'b1, 1'b1, RES_TIMEOUT, NO_CFG},
        '{ROW_SETTLE,   1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_SETTINGS, 1'b0, 1'b0, 1'b0, RES_IDLE,    SHORT_RUN},
        '{ROW_TICK,     1'b1, 1'b0, 1'b1, RES_PULSE,   NO_CFG},
        '{ROW_TICK,     1'b0, 1'b1, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b1, 1'b1, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b1, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b1, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b1, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b1, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_TICK,     1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_SETTLE,   1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG},
        '{ROW_SETTINGS, 1'b0, 1'b0, 1'b0, RES_IDLE,    WIDEST},
        '{ROW_TICK,     1'b1, 1'b0, 1'b1, RES_TLOW,    NO_CFG},
        '{ROW_SETTLE,   1'b0, 1'b0, 1'b0, RES_IDLE,    NO_CFG}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_start_req;
    logic                  i_echo_level;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_trig_level;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_timed_out;
    logic [DIST_W-1:0]     o_distance_cm;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_cfg          cfg_shadow;
    t_ranger_phase ranger_phase;
    logic [15:0]   phase_ticks;
    logic [15:0]   echo_ticks;
    logic          echo_armed;
    logic          echo_last;

    t_range_res    pending_ranges [$];
    int unsigned   err_count  = 0;
    int unsigned   tick_count = 0;
    logic          quiet      = 1'b0;

    ultrasonic_range_controller_core #(
        .SCALE_DIVISOR(SCALE_DIV_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_req   (i_start_req),
        .i_echo_level  (i_echo_level),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_trig_level  (o_trig_level),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_timed_out   (o_timed_out),
        .o_distance_cm (o_distance_cm),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 36);
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic step_ranger(input logic start, input logic echo, output t_range_res res);
        logic        rising;
        logic        falling;
        logic [31:0] scaled;
        res     = '0;
        rising  = echo && !echo_last;
        falling = !echo && echo_last;
        if (ranger_phase == RANGER_IDLE && start) begin
            ranger_phase = RANGER_TLOW;
            phase_ticks  = '0;
            echo_ticks   = '0;
            echo_armed   = 1'b0;
        end
        if (ranger_phase == RANGER_TLOW) begin
            if (phase_ticks >= 16'(cfg_shadow.trig_low_us)) begin
                ranger_phase = RANGER_THIGH;
                phase_ticks  = '0;
            end else begin
                phase_ticks = sat_inc(phase_ticks);
            end
        end
        if (ranger_phase == RANGER_THIGH) begin
            if (phase_ticks >= 16'(cfg_shadow.trig_high_us)) begin
                ranger_phase = RANGER_WAIT;
                phase_ticks  = '0;
            end else begin
                phase_ticks = sat_inc(phase_ticks);
                res.trig    = 1'b1;
            end
        end
        if (ranger_phase == RANGER_WAIT) begin
            phase_ticks = sat_inc(phase_ticks);
            if (echo_armed) begin
                echo_ticks = sat_inc(echo_ticks);
            end
            if (rising) begin
                echo_armed = 1'b1;
                echo_ticks = '0;
            end else if (falling && echo_armed) begin
                res.done     = 1'b1;
                scaled       = 32'(echo_ticks) * 32'(cfg_shadow.speed_scale) / SCALE_DIV_DEF;
                res.range_cm = (scaled > 32'(DIST_W'('1))) ? DIST_W'('1)
                                                           : scaled[DIST_W-1:0];
            end
            if (!res.done && phase_ticks >= cfg_shadow.timeout_us) begin
                res.done = 1'b1;
                res.tmo  = 1'b1;
            end
            if (res.done) begin
                ranger_phase = RANGER_IDLE;
                phase_ticks  = '0;
                echo_armed   = 1'b0;
            end
        end
        echo_last = echo;
        res.busy  = (ranger_phase != RANGER_IDLE);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_range_res got;
        t_range_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_trig_level, o_busy_res, o_done_res, o_timed_out, o_distance_cm};
            if (pending_ranges.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing pending, expected none, actual %p",
                         $time, got);
            end else begin
                want = pending_ranges.pop_front();
                compare_field("trig_level", want.trig, got.trig);
                compare_field("busy_res", want.busy, got.busy);
                compare_field("done_res", want.done, got.done);
                compare_field("timed_out", want.tmo, got.tmo);
                compare_field("distance_cm", want.range_cm, got.range_cm);
            end
        end
    end

    task automatic send_tick(input logic start, input logic echo);
        t_range_res predicted;
        while (!quiet && $urandom_range(0, 99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_start_req  <= start;
        i_echo_level <= echo;
        do @(posedge i_clk); while (o_stall);
        step_ranger(start, echo, predicted);
        pending_ranges.push_back(predicted);
        tick_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_TRIG_LOW, 16'(c.trig_low_us));
        write_reg(CFG_TRIG_HIGH, 16'(c.trig_high_us));
        write_reg(CFG_TIMEOUT, c.timeout_us);
        write_reg(CFG_SCALE, 16'(c.speed_scale));
        i_cfg_valid <= 1'b0;
        cfg_shadow = c;
    endtask

    // A measurement still running is closed with a clean echo pulse once it waits.
    task automatic settle();
        while (ranger_phase != RANGER_IDLE) begin
            send_tick(1'b0, (ranger_phase == RANGER_WAIT) && !echo_last);
        end
        i_valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_measurement();
        int unsigned lead;
        int unsigned lim;
        int unsigned delay;
        int unsigned width;
        lead = cfg_shadow.trig_low_us + cfg_shadow.trig_high_us;
        lim  = cfg_shadow.timeout_us + 4;
        if (lim > 120) begin
            lim = 120;
        end
        delay = $urandom_range(0, lim / 2);
        width = $urandom_range(1, lim);
        send_tick(1'b1, 1'b0);
        repeat (lead) send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
        repeat (delay) send_tick($urandom_range(0, 7) == 0, 1'b0);
        repeat (width) send_tick($urandom_range(0, 7) == 0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    initial begin : stimulus
        t_cfg        c;
        int unsigned phase_end;
        int unsigned roll;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_start_req  <= 1'b0;
        i_echo_level <= 1'b0;
        i_stall      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        cfg_shadow   = '{TRIG_LOW_RST, TRIG_HIGH_RST, TIMEOUT_RST, SCALE_RST};
        ranger_phase = RANGER_IDLE;
        phase_ticks  = '0;
        echo_ticks   = '0;
        echo_armed   = 1'b0;
        echo_last    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            case (DIRECTED_PLAN[r].kind)
                ROW_TICK: begin
                    send_tick(DIRECTED_PLAN[r].start, DIRECTED_PLAN[r].echo);
                    if (DIRECTED_PLAN[r].typed) begin
                        pending_ranges[pending_ranges.size() - 1] = DIRECTED_PLAN[r].want;
                    end
                end
                ROW_SETTINGS: load_settings(DIRECTED_PLAN[r].cfg);
                default: settle();
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                LONG_PHASE: c = LONG_WAIT;
                NARROW_PHASE: c = NARROWEST;
                default: begin
                    c.trig_low_us  = 8'($urandom_range(0, 6));
                    c.trig_high_us = 8'($urandom_range(0, 6));
                    c.timeout_us   = 16'($urandom_range(1, 100));
                    c.speed_scale  = 8'($urandom_range(1, 255));
                end
            endcase
            load_settings(c);
            quiet     = (p == QUIET_PHASE);
            phase_end = tick_count + PHASE_TICKS;
            while (tick_count < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    run_measurement();
                end else if (roll < 90) begin
                    repeat ($urandom_range(1, 8)) begin
                        send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 1));
                    end
                end else begin
                    repeat ($urandom_range(1, 5)) send_tick(1'b0, 1'b0);
                end
            end
            settle();
            quiet = 1'b0;
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
